/* design/sdcf_pkg.sv */
// ---------------------------------------------------------------------------
// sdcf_pkg
// Shared types and constants of the spring-damper cable force block.
// ---------------------------------------------------------------------------
package sdcf_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_REST_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_STIFFNESS    = 3'd1;
    localparam logic [2:0] CFG_INIT_TENSION = 3'd2;
    localparam logic [2:0] CFG_KNEE_STRETCH = 3'd3;
    localparam logic [2:0] CFG_DAMPING      = 3'd4;
    localparam logic [2:0] CFG_START_LENGTH = 3'd5;

    // Status returned by each arithmetic unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

/* design/sdcf_in_if.sv */
// ---------------------------------------------------------------------------
// sdcf_in_if
// Input item channel: two anchor positions and a time step.
// ---------------------------------------------------------------------------
interface sdcf_in_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] first_x;
    logic [W-1:0] first_y;
    logic [W-1:0] first_z;
    logic [W-1:0] second_x;
    logic [W-1:0] second_y;
    logic [W-1:0] second_z;
    logic [W-1:0] time_step;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z, time_step,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z, time_step,
        output ready
    );
endinterface

/* design/sdcf_out_if.sv */
// ---------------------------------------------------------------------------
// sdcf_out_if
// Result item channel: impulse vector, length, tension and error flag.
// ---------------------------------------------------------------------------
interface sdcf_out_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] impulse_x;
    logic [W-1:0] impulse_y;
    logic [W-1:0] impulse_z;
    logic [W-1:0] cable_length;
    logic [W-1:0] spring_tension;
    logic         bad_step;

    modport source (
        output valid, impulse_x, impulse_y, impulse_z, cable_length, spring_tension, bad_step,
        input  ready
    );
    modport sink (
        input  valid, impulse_x, impulse_y, impulse_z, cable_length, spring_tension, bad_step,
        output ready
    );
endinterface

/* design/spring_damper_cable_force_top.sv */
// ---------------------------------------------------------------------------
// spring_damper_cable_force_top
// Bilinear spring-damper cable: length, tension, damping and impulse.
// ---------------------------------------------------------------------------
// One item at a time runs through a sequencer that drives a serial multiplier,
// a restoring divider and a bit-serial square root. Each item uses 3 squares,
// the root, up to 2 tension multiplies and 1 divide, a damping multiply and
// divide, the impulse multiply and up to 3 component multiply/divide pairs,
// in that order. With the default WORD_WIDTH and FRAC_BITS, values are Q16.16.
// A zero time step returns with bad_step set and leaves the stored length
// unchanged. The finished result sits in an output register, so the next
// item may start while it waits.
module spring_damper_cable_force_top #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [WORD_WIDTH-1:0] i_cfg_data,
    sdcf_in_if.sink               i_item,
    sdcf_out_if.source            o_result
);
    localparam int W    = WORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int IMPF = 2 * W + 1 - F;
    localparam int IMPW = (IMPF > 64) ? 64 : IMPF;
    localparam int MA   = DW;
    localparam int MB   = (IMPW > DW) ? IMPW : DW;
    localparam int PW   = MA + MB;
    localparam int RW   = DW + 1;
    localparam int SW   = 2 * RW;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_TEN, S_TMUL1, S_TMUL2, S_TDIV, S_DAMP,
        S_DMUL, S_DDIV, S_IMUL, S_CMUL, S_CDIV, S_FIN, S_BAD
    } t_state;

    t_state          r_state;
    logic            r_busy;
    logic [1:0]      r_k;
    logic [2:0]      r_sgn;
    logic [DW-1:0]   r_mag [3];
    logic [W-1:0]    r_dt;
    logic [SW-1:0]   r_sq;
    logic [DW-1:0]   r_len;
    logic [W-1:0]    r_ls;
    logic [W-1:0]    r_st;
    logic            r_beyond;
    logic [W-1:0]    r_stf;
    logic [W-1:0]    r_t;
    logic            r_grow;
    logic [W-1:0]    r_delta;
    logic [W:0]      r_m;
    logic [IMPW-1:0] r_imp;
    logic [PW-1:0]   r_prod;
    logic [W-1:0]    r_c [3];
    logic [W-1:0]    r_prev;

    // Configuration registers
    logic [W-1:0]    r_rest, r_stiff, r_itens, r_knee, r_damp;

    // Output register
    logic            r_ovalid;
    logic [W-1:0]    r_o_ix, r_o_iy, r_o_iz, r_o_len, r_o_ten;
    logic            r_o_bad;

    // Unit interfaces
    logic                mul_start, div_start, sqrt_start;
    logic [MA-1:0]       mul_a;
    logic [MB-1:0]       mul_b;
    logic [PW-1:0]       mul_p;
    logic [DW-1:0]       div_d;
    logic [PW-1:0]       div_q;
    logic [RW-1:0]       root;
    sdcf_pkg::t_unit_sts mul_sts, div_sts, sqrt_sts;

    logic            in_acc;
    logic [W:0]      diff [3];
    logic [W-1:0]    first  [3];
    logic [W-1:0]    second [3];
    logic [PW-1:0]   p_shift;
    logic [W-1:0]    stf;
    logic [W:0]      t_sum;
    logic [W-1:0]    st_now;
    logic            out_free;
    logic [W-1:0]    c_sat;
    logic            c_big;
    logic [W-1:0]    damp_v;

    assign in_acc   = i_item.valid && i_item.ready;
    assign out_free = !r_ovalid || o_result.ready;
    assign first[0]  = i_item.first_x;
    assign first[1]  = i_item.first_y;
    assign first[2]  = i_item.first_z;
    assign second[0] = i_item.second_x;
    assign second[1] = i_item.second_y;
    assign second[2] = i_item.second_z;

    // Anchor differences, sign-extended by one bit
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {second[k][W-1], second[k]} - {first[k][W-1], first[k]};
        end
    end

    // Shared unit operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_d = DW'(r_len);
        case (r_state)
            S_SQ: begin
                mul_a = r_mag[r_k];
                mul_b = MB'(r_mag[r_k]);
            end
            S_TMUL1: begin
                mul_a = MA'(r_stiff);
                mul_b = MB'(r_st);
            end
            S_TMUL2: begin
                mul_a = MA'(r_itens);
                mul_b = MB'(r_st);
            end
            S_DMUL: begin
                mul_a = MA'(r_damp);
                mul_b = MB'(r_delta);
            end
            S_IMUL: begin
                mul_a = MA'(r_m);
                mul_b = MB'(r_dt);
            end
            S_CMUL: begin
                mul_a = r_mag[r_k];
                mul_b = MB'(r_imp);
            end
            S_TDIV:  div_d = DW'(r_knee);
            S_DDIV:  div_d = DW'(r_dt);
            default: div_d = DW'(r_len);
        endcase
    end

    assign mul_start  = !r_busy && (r_state == S_SQ || r_state == S_TMUL1 ||
                        r_state == S_TMUL2 || r_state == S_DMUL ||
                        r_state == S_IMUL || r_state == S_CMUL);
    assign div_start  = !r_busy && (r_state == S_TDIV || r_state == S_DDIV ||
                        r_state == S_CDIV);
    assign sqrt_start = !r_busy && r_state == S_SQRT;

    // Product scaling and saturation
    assign p_shift = mul_p >> F;
    assign stf     = (|p_shift[PW-1:W]) ? '1 : p_shift[W-1:0];
    assign st_now  = (r_ls > r_rest) ? r_ls - r_rest : '0;
    assign damp_v  = (div_q > PW'(r_t)) ? r_t : div_q[W-1:0];

    always_comb begin
        t_sum = '0;
        case (r_state)
            S_TMUL1: t_sum = {1'b0, stf} + {1'b0, r_itens};
            S_TDIV:  t_sum = {1'b0, r_stf} + {1'b0, div_q[W-1:0]};
            default: t_sum = '0;
        endcase
    end

    // Signed saturation of one impulse component
    always_comb begin
        if (r_sgn[r_k]) begin
            c_big = div_q >= (PW'(1) << (W - 1));
            c_sat = c_big ? (W'(1) << (W - 1)) : W'(0) - div_q[W-1:0];
        end else begin
            c_big = div_q > PW'((W'(1) << (W - 1)) - W'(1));
            c_sat = c_big ? ((W'(1) << (W - 1)) - W'(1)) : div_q[W-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_prev   <= '0;
            r_rest   <= '0;
            r_stiff  <= W'(1) << F;
            r_itens  <= '0;
            r_knee   <= '0;
            r_damp   <= '0;
            r_k      <= '0;
        end else begin
            if (o_result.valid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            if (mul_start || div_start || sqrt_start) begin
                r_busy <= 1'b1;
            end

            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdcf_pkg::CFG_REST_LENGTH:  r_rest  <= i_cfg_data;
                    sdcf_pkg::CFG_STIFFNESS:    r_stiff <= i_cfg_data;
                    sdcf_pkg::CFG_INIT_TENSION: r_itens <= i_cfg_data;
                    sdcf_pkg::CFG_KNEE_STRETCH: r_knee  <= i_cfg_data;
                    sdcf_pkg::CFG_DAMPING:      r_damp  <= i_cfg_data;
                    sdcf_pkg::CFG_START_LENGTH: r_prev  <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dt <= i_item.time_step;
                        r_sq <= '0;
                        r_k  <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_sgn[k] <= diff[k][W];
                            r_mag[k] <= diff[k][W] ? DW'(~diff[k] + 1'b1) : diff[k];
                        end
                        r_state <= (i_item.time_step == '0) ? S_BAD : S_SQ;
                    end
                end
                S_SQ: begin
                    if (mul_sts.done) begin
                        r_busy <= 1'b0;
                        r_sq   <= r_sq + SW'(mul_p);
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_SQRT: begin
                    if (sqrt_sts.done) begin
                        r_busy  <= 1'b0;
                        r_len   <= root[DW-1:0];
                        r_ls    <= root[W] ? '1 : root[W-1:0];
                        r_state <= S_TEN;
                    end
                end
                S_TEN: begin
                    r_st     <= st_now;
                    r_beyond <= st_now > r_knee;
                    if (st_now == '0) begin
                        r_t     <= '0;
                        r_state <= S_DAMP;
                    end else begin
                        r_state <= S_TMUL1;
                    end
                end
                S_TMUL1: begin
                    if (mul_sts.done) begin
                        r_busy <= 1'b0;
                        r_stf  <= stf;
                        if (r_beyond) begin
                            r_t     <= t_sum[W] ? '1 : t_sum[W-1:0];
                            r_state <= S_DAMP;
                        end else begin
                            r_state <= S_TMUL2;
                        end
                    end
                end
                S_TMUL2: begin
                    if (mul_sts.done) begin
                        r_busy  <= 1'b0;
                        r_prod  <= mul_p;
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_sts.done) begin
                        r_busy  <= 1'b0;
                        r_t     <= t_sum[W] ? '1 : t_sum[W-1:0];
                        r_state <= S_DAMP;
                    end
                end
                S_DAMP: begin
                    r_grow  <= r_ls >= r_prev;
                    r_delta <= (r_ls >= r_prev) ? r_ls - r_prev : r_prev - r_ls;
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    if (mul_sts.done) begin
                        r_busy  <= 1'b0;
                        r_prod  <= mul_p;
                        r_state <= S_DDIV;
                    end
                end
                S_DDIV: begin
                    if (div_sts.done) begin
                        r_busy  <= 1'b0;
                        r_m     <= r_grow ? {1'b0, r_t} + {1'b0, damp_v}
                                          : {1'b0, r_t} - {1'b0, damp_v};
                        r_state <= S_IMUL;
                    end
                end
                S_IMUL: begin
                    if (mul_sts.done) begin
                        r_busy <= 1'b0;
                        r_imp  <= (|p_shift[PW-1:IMPW]) ? '1 : p_shift[IMPW-1:0];
                        r_k    <= '0;
                        if (r_len == '0) begin
                            for (int k = 0; k < 3; k++) begin
                                r_c[k] <= '0;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_CMUL: begin
                    if (mul_sts.done) begin
                        r_busy  <= 1'b0;
                        r_prod  <= mul_p;
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (div_sts.done) begin
                        r_busy     <= 1'b0;
                        r_c[r_k]   <= c_sat;
                        if (r_k == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_o_ix   <= r_c[0];
                        r_o_iy   <= r_c[1];
                        r_o_iz   <= r_c[2];
                        r_o_len  <= r_ls;
                        r_o_ten  <= r_t;
                        r_o_bad  <= 1'b0;
                        r_prev   <= r_ls;
                        r_state  <= S_IDLE;
                    end
                end
                S_BAD: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_o_ix   <= '0;
                        r_o_iy   <= '0;
                        r_o_iz   <= '0;
                        r_o_len  <= '0;
                        r_o_ten  <= '0;
                        r_o_bad  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Shared arithmetic units
    sdcf_mul #(.AW(MA), .BW(MB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_p),
        .o_sts   (mul_sts)
    );

    sdcf_div #(.NW(PW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (div_d),
        .o_quot  (div_q),
        .o_sts   (div_sts)
    );

    sdcf_sqrt #(.RW(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sq),
        .o_root  (root),
        .o_sts   (sqrt_sts)
    );

    // Ports
    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_ovalid;
    assign o_result.impulse_x      = r_o_ix;
    assign o_result.impulse_y      = r_o_iy;
    assign o_result.impulse_z      = r_o_iz;
    assign o_result.cable_length   = r_o_len;
    assign o_result.spring_tension = r_o_ten;
    assign o_result.bad_step       = r_o_bad;

    // Checks
    a_bad_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_item.time_step == '0 |=> r_state == S_BAD)
        else $error("zero time step not routed to error path");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier started while busy");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({mul_sts.busy, div_sts.busy, sqrt_sts.busy}) <= 1)
        else $error("more than one arithmetic unit active");

    a_prev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BAD && !i_cfg_we |=> $stable(r_prev))
        else $error("stored length changed on bad step");
endmodule

/* design/sdcf_mul.sv */
// ---------------------------------------------------------------------------
// sdcf_mul
// Shift-and-add multiplier, one bit of the second operand per cycle.
// ---------------------------------------------------------------------------
module sdcf_mul #(
    parameter int AW = 33,
    parameter int BW = 49
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    output logic [AW+BW-1:0]     o_prod,
    output sdcf_pkg::t_unit_sts  o_sts
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one partial product a cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a   <= PW'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_prod     = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule

/* design/sdcf_div.sv */
// ---------------------------------------------------------------------------
// sdcf_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sdcf_div #(
    parameter int NW = 82,
    parameter int DW = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    output logic [NW-1:0]        o_quot,
    output sdcf_pkg::t_unit_sts  o_sts
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_n;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_n[NW-1]};
    assign fits  = trial >= {1'b0, r_d};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where numerator bits leave
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
            r_n   <= {r_n[NW-2:0], fits};
        end
    end

    assign o_quot     = r_n;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule

/* design/sdcf_sqrt.sv */
// ---------------------------------------------------------------------------
// sdcf_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module sdcf_sqrt #(
    parameter int RW = 34
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2*RW-1:0]      i_rad,
    output logic [RW-1:0]        o_root,
    output sdcf_pkg::t_unit_sts  o_sts
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] r_x;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [RW+2:0]   cur;
    logic [RW+2:0]   trial;
    logic            fits;

    assign cur   = {r_rem, r_x[2*RW-1:2*RW-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = cur >= trial;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: two radicand bits per step
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? (RW+1)'(cur - trial) : cur[RW:0];
            r_root <= {r_root[RW-2:0], fits};
            r_x    <= r_x << 2;
        end
    end

    assign o_root     = r_root;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule

/* tb/sdcf_force_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdcf_force_checker
// Watches the item and result channels and the register port of the cable
// force block. It computes the expected length, tension, impulse and error
// flag for every accepted item, and compares each result field by field.
// ---------------------------------------------------------------------------
module sdcf_force_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    sdcf_in_if.sink     i_item,
    sdcf_out_if.sink    i_result,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_bad_step_count,
    output int          o_zero_len_count
);
    typedef struct packed {
        logic [31:0] imp_x;
        logic [31:0] imp_y;
        logic [31:0] imp_z;
        logic [31:0] length;
        logic [31:0] tension;
        logic        bad;
    } t_force;

    localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF;

    t_force      force_q[$];
    logic [31:0] rest_len, stiff, init_ten, knee, damp_coef, prev_len;

    // Truncating divide of a 128-bit value, saturated to 64 bits
    function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d);
        logic [127:0] q;
        q = n / {64'd0, d};
        return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
    endfunction

    function automatic logic [63:0] shr_sat(input logic [127:0] p);
        logic [127:0] s;
        s = p >> 16;
        return (s[127:64] != 0) ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [63:0] umin64(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // Force of one cable step; updates the stored length unless the time step is zero
    function automatic t_force cable_force(input logic [31:0] f[3], input logic [31:0] s[3],
                                           input logic [31:0] dt);
        t_force       r;
        logic [63:0]  mag[3];
        logic         neg[3];
        logic [127:0] sq;
        logic [63:0]  root, len, st, ten, delta, dmp, m, imp, c, cand;
        logic signed [63:0] dv;
        logic [31:0]  comp[3];
        logic         grow;
        r = '0;
        if (dt == 0) begin
            r.bad = 1'b1;
            return r;
        end
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            dv = $signed({{32{s[k][31]}}, s[k]}) - $signed({{32{f[k][31]}}, f[k]});
            neg[k] = dv < 0;
            mag[k] = neg[k] ? -dv : dv;
            sq += {64'd0, mag[k]} * {64'd0, mag[k]};
        end
        root = 0;
        for (int i = 63; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= sq) root = cand;
        end
        len = umin64(root, WORD_MAX);
        st = (len > rest_len) ? len - rest_len : 0;
        if (st > knee)
            ten = umin64(shr_sat({64'd0, stiff} * {64'd0, st}), WORD_MAX) + init_ten;
        else if (st > 0)
            ten = umin64(shr_sat({64'd0, stiff} * {64'd0, st}), WORD_MAX)
                + div_sat({64'd0, init_ten} * {64'd0, st}, knee);
        else
            ten = 0;
        ten = umin64(ten, WORD_MAX);
        grow = len >= prev_len;
        delta = grow ? len - prev_len : prev_len - len;
        dmp = umin64(div_sat({64'd0, damp_coef} * {64'd0, delta}, dt), ten);
        m = grow ? ten + dmp : ten - dmp;
        imp = shr_sat({64'd0, m} * {64'd0, dt});
        for (int k = 0; k < 3; k++) begin
            c = (root != 0) ? div_sat({64'd0, mag[k]} * {64'd0, imp}, root) : 0;
            if (neg[k]) comp[k] = 32'(-umin64(c, POS_MAX + 1));
            else        comp[k] = 32'(umin64(c, POS_MAX));
        end
        r.imp_x = comp[0];
        r.imp_y = comp[1];
        r.imp_z = comp[2];
        r.length = len[31:0];
        r.tension = ten[31:0];
        prev_len = len[31:0];
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %0t: %s got %h want %h", $time, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
        o_bad_step_count = 0;
        o_zero_len_count = 0;
    end

    always @(posedge i_clk) begin
        t_force got, want;
        if (!i_rst_n) begin
            rest_len  = 0;
            stiff     = 32'd65536;
            init_ten  = 0;
            knee      = 0;
            damp_coef = 0;
            prev_len  = 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdcf_pkg::CFG_REST_LENGTH:  rest_len = i_cfg_data;
                    sdcf_pkg::CFG_STIFFNESS:    stiff = i_cfg_data;
                    sdcf_pkg::CFG_INIT_TENSION: init_ten = i_cfg_data;
                    sdcf_pkg::CFG_KNEE_STRETCH: knee = i_cfg_data;
                    sdcf_pkg::CFG_DAMPING:      damp_coef = i_cfg_data;
                    sdcf_pkg::CFG_START_LENGTH: prev_len = i_cfg_data;
                    default: ;
                endcase
            end
            // accepted item
            if (i_item.valid && i_item.ready) begin
                want = cable_force('{i_item.first_x, i_item.first_y, i_item.first_z},
                                   '{i_item.second_x, i_item.second_y, i_item.second_z},
                                   i_item.time_step);
                if (want.bad) o_bad_step_count++;
                else if (want.length == 0) o_zero_len_count++;
                force_q.push_back(want);
            end
            // accepted result
            if (i_result.valid && i_result.ready) begin
                o_result_count++;
                got = '{i_result.impulse_x, i_result.impulse_y, i_result.impulse_z,
                        i_result.cable_length, i_result.spring_tension, i_result.bad_step};
                if (force_q.size() == 0) begin
                    $display("mismatch %0t: result with nothing expected", $time);
                    o_fail_count++;
                end else begin
                    want = force_q.pop_front();
                    if (got.imp_x !== want.imp_x) report("impulse_x", got.imp_x, want.imp_x);
                    if (got.imp_y !== want.imp_y) report("impulse_y", got.imp_y, want.imp_y);
                    if (got.imp_z !== want.imp_z) report("impulse_z", got.imp_z, want.imp_z);
                    if (got.length !== want.length)
                        report("cable_length", got.length, want.length);
                    if (got.tension !== want.tension)
                        report("spring_tension", got.tension, want.tension);
                    if (got.bad !== want.bad) report("bad_step", 32'(got.bad), 32'(want.bad));
                end
            end
        end
        o_pending = force_q.size();
    end
endmodule

/* tb/tb_spring_damper_cable_force_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_spring_damper_cable_force_top
// Drives anchor pairs and time steps into the cable force block under
// several register settings, with random idling on both channels; the
// checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_spring_damper_cable_force_top;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = 0;
    logic [31:0] cfg_data = 0;
    logic        quiet = 0;
    int          fail_count, pending, result_count, bad_count, zero_count;
    int          item_count = 0;

    sdcf_in_if  #(.W(32)) item_ch ();
    sdcf_out_if #(.W(32)) result_ch ();

    spring_damper_cable_force_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_item(item_ch.sink), .o_result(result_ch.source)
    );

    sdcf_force_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_item(item_ch.sink), .i_result(result_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count),
        .o_bad_step_count(bad_count), .o_zero_len_count(zero_count)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        item_ch.valid = 0;
        {item_ch.first_x, item_ch.first_y, item_ch.first_z} = '0;
        {item_ch.second_x, item_ch.second_y, item_ch.second_z} = '0;
        item_ch.time_step = 0;
        result_ch.ready = 0;
    end

    // Receiver stall bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            result_ch.ready <= 1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 1)) begin
                result_ch.ready <= 0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
    end

    // One register write, after which the write enable is dropped again
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // Stop sending and wait for the block to drain before touching registers
    task automatic drain();
        item_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Valid stays high into the next item unless an idle burst comes first
    task automatic send_item(input logic [31:0] fx, fy, fz, sx, sy, sz, dt);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        item_ch.valid <= 1;
        item_ch.first_x <= fx;
        item_ch.first_y <= fy;
        item_ch.first_z <= fz;
        item_ch.second_x <= sx;
        item_ch.second_y <= sy;
        item_ch.second_z <= sz;
        item_ch.time_step <= dt;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        item_count++;
    endtask

    function automatic logic [31:0] rnd_coord(input int scale);
        case (scale)
            0: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            1: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rnd_step();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return 1;
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    task automatic random_phase(input int n);
        int sc;
        logic [31:0] fx, fy, fz;
        for (int i = 0; i < n; i++) begin
            sc = $urandom_range(0, 2);
            fx = rnd_coord(sc);
            fy = rnd_coord(sc);
            fz = rnd_coord(sc);
            if ($urandom_range(0, 19) == 0)
                send_item(fx, fy, fz, fx, fy, fz, rnd_step());
            else
                send_item(fx, fy, fz, rnd_coord(sc), rnd_coord(sc), rnd_coord(sc), rnd_step());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset settings
        send_item(0, 0, 0, 0, 0, 0, 32'h0001_0000);                 // zero length
        send_item(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0);     // zero step
        send_item(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 32'h0001_0000);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 0, 32'h8000_0000, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
        drain();

        // Knee and damping with shrink then grow
        write_reg(sdcf_pkg::CFG_REST_LENGTH, 32'h0002_0000);
        write_reg(sdcf_pkg::CFG_STIFFNESS, 32'h0004_0000);
        write_reg(sdcf_pkg::CFG_INIT_TENSION, 32'h0003_0000);
        write_reg(sdcf_pkg::CFG_KNEE_STRETCH, 32'h0002_0000);
        write_reg(sdcf_pkg::CFG_DAMPING, 32'h0002_0000);
        write_reg(sdcf_pkg::CFG_START_LENGTH, 32'h000A_0000);
        write_reg(3'd7, 32'hDEAD_BEEF);                                // unknown index
        send_item(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_8000);       // no stretch, shrink
        send_item(0, 0, 0, 32'h0003_0000, 0, 0, 32'h0000_8000);       // knee segment
        send_item(0, 0, 0, 32'h0004_0000, 0, 0, 32'h0000_8000);       // at knee
        send_item(0, 0, 0, 32'hFFF0_0000, 32'h0010_0000, 0, 32'h0000_8000);
        send_item(0, 0, 0, 32'h0009_0000, 0, 0, 0);                    // state held
        send_item(0, 0, 0, 32'h0009_0000, 0, 0, 32'h0001_0000);
        drain();

        // Extreme register values
        write_reg(sdcf_pkg::CFG_REST_LENGTH, 32'hFFFF_FFFF);
        write_reg(sdcf_pkg::CFG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(sdcf_pkg::CFG_INIT_TENSION, 32'hFFFF_FFFF);
        write_reg(sdcf_pkg::CFG_KNEE_STRETCH, 32'hFFFF_FFFF);
        write_reg(sdcf_pkg::CFG_DAMPING, 32'hFFFF_FFFF);
        write_reg(sdcf_pkg::CFG_START_LENGTH, 32'hFFFF_FFFF);
        send_item(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF);
        random_phase(40);
        drain();

        write_reg(sdcf_pkg::CFG_REST_LENGTH, 0);
        write_reg(sdcf_pkg::CFG_STIFFNESS, 1);
        write_reg(sdcf_pkg::CFG_INIT_TENSION, 0);
        write_reg(sdcf_pkg::CFG_KNEE_STRETCH, 0);
        write_reg(sdcf_pkg::CFG_DAMPING, 0);
        write_reg(sdcf_pkg::CFG_START_LENGTH, 0);
        random_phase(60);
        drain();

        // Random settings
        for (int p = 0; p < 6; p++) begin
            write_reg(sdcf_pkg::CFG_REST_LENGTH, $urandom_range(0, 32'h0040_0000));
            write_reg(sdcf_pkg::CFG_STIFFNESS, $urandom_range(1, 32'h0100_0000));
            write_reg(sdcf_pkg::CFG_INIT_TENSION,
                      (p == 2) ? $urandom : $urandom_range(0, 32'h0100_0000));
            write_reg(sdcf_pkg::CFG_KNEE_STRETCH,
                      (p == 3) ? $urandom : $urandom_range(0, 32'h0100_0000));
            write_reg(sdcf_pkg::CFG_DAMPING,
                      (p == 4) ? $urandom : $urandom_range(0, 32'h0010_0000));
            write_reg(sdcf_pkg::CFG_START_LENGTH, $urandom);
            random_phase(p == 5 ? 50 : 60);
            if (p == 1) begin
                // hold off until every result is back
                drain();
            end
            if (p == 4) quiet = 1;
            drain();
        end
        random_phase(20);

        drain();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results (%0d zero steps, %0d zero lengths)",
                 item_count, result_count, bad_count, zero_count);
        $display("Register settings swept from reset values through both extremes.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
